>>> hdl/wsd_pkg.sv
// WebSocket deframer package: parser phase, status codes, state and result structs.
// No dependencies; used by wsd_step and websocket_frame_deframer.
`timescale 1ns / 1ps

package wsd_pkg;

	// Parser phase, one-hot
	typedef enum logic [6:0] {
		PH_HDR0    = 7'b0000001,
		PH_HDR1    = 7'b0000010,
		PH_EXT0    = 7'b0000100,
		PH_EXT1    = 7'b0001000,
		PH_MASK    = 7'b0010000,
		PH_PAYLOAD = 7'b0100000,
		PH_SKIP    = 7'b1000000
	} phase_t;

	// Result status codes
	localparam logic [2:0] ST_BYTE    = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_NOTTEXT = 3'd2;
	localparam logic [2:0] ST_LEN64   = 3'd3;
	localparam logic [2:0] ST_TRUNC   = 3'd4;

	// Header field constants
	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// Parser state carried between bytes
	typedef struct packed {
		phase_t      phase;
		logic [15:0] length;
		logic [15:0] count;
		logic [31:0] mask;
		logic [1:0]  hcnt;
	} parse_state_t;

	// One result item
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
	} result_t;

endpackage

>>> hdl/wsd_step.sv
// Per-byte parser step: next parser state and the optional result for one byte.
// Purely combinational; depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_step (
	input  wsd_pkg::parse_state_t cur,
	input  logic [7:0]            in_byte,
	input  logic                  buffer_end,
	output wsd_pkg::parse_state_t nxt,
	output wsd_pkg::result_t      res
);

	logic [6:0]  len7;
	logic [15:0] cnt_inc;
	logic [7:0]  key;
	wsd_pkg::phase_t after_frame;

	assign len7        = in_byte[6:0];
	assign cnt_inc     = cur.count + 16'd1;
	assign key         = cur.mask[8*cur.count[1:0] +: 8];
	assign after_frame = buffer_end ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_SKIP;

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.phase)
			wsd_pkg::PH_HDR0: begin
				nxt.length = '0;
				nxt.count  = '0;
				nxt.mask   = '0;
				nxt.hcnt   = '0;
				if (buffer_end) begin
					nxt.phase = wsd_pkg::PH_HDR0;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_TRUNC, last: 1'b1};
				end else if (in_byte[3:0] != wsd_pkg::OPC_TEXT) begin
					nxt.phase = wsd_pkg::PH_SKIP;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_NOTTEXT, last: 1'b1};
				end else begin
					nxt.phase = wsd_pkg::PH_HDR1;
				end
			end
			wsd_pkg::PH_HDR1: begin
				if (len7 == wsd_pkg::LEN_EXT64) begin
					nxt.phase = after_frame;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_LEN64, last: 1'b1};
				end else if (buffer_end) begin
					nxt.phase = wsd_pkg::PH_HDR0;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_TRUNC, last: 1'b1};
				end else if (len7 == wsd_pkg::LEN_EXT16) begin
					nxt.phase = wsd_pkg::PH_EXT0;
				end else begin
					nxt.length = {9'd0, len7};
					nxt.phase  = wsd_pkg::PH_MASK;
				end
			end
			wsd_pkg::PH_EXT0: begin
				if (buffer_end) begin
					nxt.phase = wsd_pkg::PH_HDR0;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_TRUNC, last: 1'b1};
				end else begin
					nxt.length = {in_byte, 8'd0};
					nxt.phase  = wsd_pkg::PH_EXT1;
				end
			end
			wsd_pkg::PH_EXT1: begin
				if (buffer_end) begin
					nxt.phase = wsd_pkg::PH_HDR0;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_TRUNC, last: 1'b1};
				end else begin
					nxt.length = {cur.length[15:8], in_byte};
					nxt.phase  = wsd_pkg::PH_MASK;
				end
			end
			wsd_pkg::PH_MASK: begin
				// mask key was cleared at the first header byte, lanes fill in order
				nxt.mask[8*cur.hcnt +: 8] = in_byte;
				nxt.hcnt = cur.hcnt + 2'd1;
				if (cur.hcnt == 2'd3 && cur.length == 16'd0) begin
					nxt.phase = after_frame;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_EMPTY, last: 1'b1};
				end else if (buffer_end) begin
					nxt.phase = wsd_pkg::PH_HDR0;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_TRUNC, last: 1'b1};
				end else if (cur.hcnt == 2'd3) begin
					nxt.phase = wsd_pkg::PH_PAYLOAD;
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				nxt.count = cnt_inc;
				if (cnt_inc == cur.length) begin
					nxt.phase = after_frame;
					res = '{valid: 1'b1, data: in_byte ^ key, status: wsd_pkg::ST_BYTE,
						last: 1'b1};
				end else if (buffer_end) begin
					nxt.phase = wsd_pkg::PH_HDR0;
					res = '{valid: 1'b1, data: 8'd0, status: wsd_pkg::ST_TRUNC, last: 1'b1};
				end else begin
					res = '{valid: 1'b1, data: in_byte ^ key, status: wsd_pkg::ST_BYTE,
						last: 1'b0};
				end
			end
			// skip phase and any stray code: drop bytes until the buffer ends
			default: begin
				nxt.phase = after_frame;
			end
		endcase
	end

endmodule

>>> hdl/websocket_frame_deframer.sv
// WebSocket text frame deframer top level: input register, parser state, result register.
// Depends on wsd_pkg and wsd_step.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------
//   input   | in_valid / in_ready  | in_byte[7:0], buffer_end
//   output  | out_valid / out_ready| out_byte[7:0], status[2:0], last
//
// One byte per cycle sustained while out_ready stays high; a byte passes the
// input register, the parser step and the result register.
// The parser state updates in the cycle a registered byte moves to the result stage.
// Reset clears the parser to the first header byte and empties both stages.
// A stall on the output holds the result; the input stage keeps filling until it
// too is full, then in_ready drops.
`timescale 1ns / 1ps

module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       buffer_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] status,
	output logic       last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       advance;
	logic       s2_free;

	wsd_pkg::parse_state_t state_q;
	wsd_pkg::parse_state_t state_next;
	wsd_pkg::result_t      res;
	wsd_pkg::result_t      res_s2;

	assign s2_free  = !res_s2.valid || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= buffer_end;
		end
	end

	// Parser step
	wsd_step u_step (
		.cur        (state_q),
		.in_byte    (byte_s1),
		.buffer_end (end_s1),
		.nxt        (state_next),
		.res        (res)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: wsd_pkg::PH_HDR0, length: 16'd0, count: 16'd0,
				mask: 32'd0, hcnt: 2'd0};
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (s2_free) begin
			res_s2 <= '{valid: advance && res.valid, data: res.data, status: res.status,
				last: res.last};
		end
	end

	assign out_valid = res_s2.valid;
	assign out_byte  = res_s2.data;
	assign status    = res_s2.status;
	assign last      = res_s2.last;

endmodule
